FILE: rtl/core/mrm_pkg.sv
`default_nettype none

package mrm_pkg;

  // Sizing
  localparam int MAX_REGS     = 4;
  localparam int FRAME_LEN    = 8;
  localparam int BUNDLE_DEPTH = (MAX_REGS + 1 > FRAME_LEN) ? MAX_REGS + 1 : FRAME_LEN;
  localparam int BIDX_W       = $clog2(BUNDLE_DEPTH);
  localparam int BCNT_W       = $clog2(BUNDLE_DEPTH + 1);
  localparam int EXP_W        = $clog2(MAX_REGS + 1);
  localparam int RXI_W        = $clog2(2 * MAX_REGS + 5);
  localparam int REGI_W       = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
  localparam int CFG_IDX_W    = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 2'd1;

  localparam logic [7:0]  SLAVE_ID_RESET = 8'd16;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd100;

  // Event kinds
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_RX    = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  // Request kinds
  localparam logic [1:0] FK_READ      = 2'd0;
  localparam logic [1:0] FK_WRITE_COIL = 2'd1;
  localparam logic [1:0] FK_WRITE_REG = 2'd2;

  // Modbus function codes
  localparam logic [7:0] FC_READ_HOLDING = 8'h03;
  localparam logic [7:0] FC_WRITE_COIL   = 8'h05;
  localparam logic [7:0] FC_WRITE_REG    = 8'h06;

  // Result kinds
  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_WORD   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FAIL    = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;
  localparam logic [1:0] ST_BAD     = 2'd3;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  func_kind;
    logic [7:0]  reg_address;
    logic [15:0] write_value;
    logic [6:0]  reg_count;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [15:0] out_data;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  // All results of one event, handed to the output side in one go
  typedef struct packed {
    logic                               valid;
    logic [BCNT_W-1:0]                  cnt;
    out_item_t [BUNDLE_DEPTH-1:0]       res;
  } bundle_t;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [15:0]          data;
  } cfg_wr_t;

  // CRC-16/MODBUS over one byte, reflected
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] func_code(input logic [1:0] fk);
    logic [7:0] code;
    case (fk)
      FK_READ:       code = FC_READ_HOLDING;
      FK_WRITE_COIL: code = FC_WRITE_COIL;
      default:       code = FC_WRITE_REG;
    endcase
    return code;
  endfunction

  // CRC through slave, function code and the zero address high byte
  function automatic logic [15:0] crc_prefix(input logic [7:0] slave, input logic [7:0] code);
    return crc_byte(crc_byte(crc_byte(CRC_INIT, slave), code), 8'h00);
  endfunction

  function automatic out_item_t status_beat(input logic [1:0] st);
    return out_item_t'{out_kind: KIND_STATUS, out_data: 16'h0000, status: st, last: 1'b1};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mrm_in_reg.sv
`default_nettype none

module mrm_in_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mrm_pkg::in_item_t in_item,
  output logic                   item_v,
  output mrm_pkg::in_item_t      item,
  input  wire logic              take
);
  import mrm_pkg::*;

  logic     item_v_r;
  in_item_t item_r;

  // free when empty or when the held event is consumed this cycle
  assign in_ready = !item_v_r || take;
  assign item_v   = item_v_r;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_v_r <= 1'b1;
    end else if (take) begin
      item_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/mrm_engine.sv
`default_nettype none

module mrm_engine (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mrm_pkg::cfg_wr_t  cfg,
  input  wire logic              item_v,
  input  wire mrm_pkg::in_item_t item,
  input  wire logic              slot_ready,
  output logic                   take,
  output mrm_pkg::bundle_t       bundle
);
  import mrm_pkg::*;

  // Configuration
  logic [7:0]  slave_id_r;
  logic [15:0] timeout_limit_r;
  logic [15:0] crc_pre_r [3];

  // Transaction state
  logic             busy_r,        busy_nxt;
  logic [1:0]       active_kind_r, active_kind_nxt;
  logic [RXI_W-1:0] rx_index_r,    rx_index_nxt;
  logic [15:0]      run_crc_r,     run_crc_nxt;
  logic [7:0]       crc_low_r,     crc_low_nxt;
  logic             mismatch_r,    mismatch_nxt;
  logic [15:0]      idle_ticks_r,  idle_ticks_nxt;
  logic [EXP_W-1:0] exp_regs_r,    exp_regs_nxt;
  logic [7:0]       high_hold_r,   high_hold_nxt;

  logic [7:0]  sent_frame_r [FRAME_LEN];
  logic [15:0] reg_store_r  [MAX_REGS];

  logic              sf_we;
  logic              rs_we;
  logic [REGI_W-1:0] rs_addr;
  logic [15:0]       rs_data;

  logic [7:0]       frame [FRAME_LEN];
  logic [15:0]      pre_sel;
  logic [15:0]      frame_crc;
  logic             bad_req;
  logic             is_read;
  logic [RXI_W-1:0] data_end;
  logic [RXI_W-1:0] idx_m4;
  logic [7:0]       rx_b;
  bundle_t          res_b;
  logic             fire;

  // Request frame, built for every start event
  always_comb begin
    is_read = (item.func_kind == FK_READ);
    case (item.func_kind)
      FK_READ:       pre_sel = crc_pre_r[FK_READ];
      FK_WRITE_COIL: pre_sel = crc_pre_r[FK_WRITE_COIL];
      FK_WRITE_REG:  pre_sel = crc_pre_r[FK_WRITE_REG];
      default:       pre_sel = 16'h0000;
    endcase
    frame[0] = slave_id_r;
    frame[1] = func_code(item.func_kind);
    frame[2] = 8'h00;
    frame[3] = item.reg_address;
    frame[4] = is_read ? 8'h00 : item.write_value[15:8];
    frame[5] = is_read ? {1'b0, item.reg_count} : item.write_value[7:0];
    frame_crc = crc_byte(crc_byte(crc_byte(pre_sel, frame[3]), frame[4]), frame[5]);
    frame[6] = frame_crc[7:0];
    frame[7] = frame_crc[15:8];
    bad_req = busy_r || (item.func_kind > FK_WRITE_REG) ||
              (is_read && ((item.reg_count == 7'd0) || (item.reg_count > 7'(MAX_REGS))));
  end

  // Event decode: next state and the results it causes
  always_comb begin
    busy_nxt        = busy_r;
    active_kind_nxt = active_kind_r;
    rx_index_nxt    = rx_index_r;
    run_crc_nxt     = run_crc_r;
    crc_low_nxt     = crc_low_r;
    mismatch_nxt    = mismatch_r;
    idle_ticks_nxt  = idle_ticks_r;
    exp_regs_nxt    = exp_regs_r;
    high_hold_nxt   = high_hold_r;
    sf_we           = 1'b0;
    rs_we           = 1'b0;
    rs_addr         = '0;
    rs_data         = 16'h0000;
    res_b           = '0;
    rx_b            = item.rx_byte;
    data_end        = RXI_W'({exp_regs_r, 1'b0}) + RXI_W'(3);
    idx_m4          = rx_index_r - RXI_W'(4);

    unique case (item.mode)
      MODE_START: begin
        if (bad_req) begin
          res_b.res[0] = status_beat(ST_BAD);
          res_b.cnt    = BCNT_W'(1);
        end else begin
          for (int i = 0; i < FRAME_LEN; i++) begin
            res_b.res[i] = out_item_t'{out_kind: KIND_TX, out_data: {8'h00, frame[i]},
                                       status: ST_OK, last: (i == FRAME_LEN - 1)};
          end
          res_b.cnt       = BCNT_W'(FRAME_LEN);
          sf_we           = 1'b1;
          busy_nxt        = 1'b1;
          active_kind_nxt = item.func_kind;
          rx_index_nxt    = '0;
          run_crc_nxt     = CRC_INIT;
          crc_low_nxt     = 8'h00;
          mismatch_nxt    = 1'b0;
          idle_ticks_nxt  = 16'h0000;
          exp_regs_nxt    = is_read ? EXP_W'(item.reg_count) : '0;
          high_hold_nxt   = 8'h00;
        end
      end

      MODE_RX: begin
        if (busy_r) begin
          idle_ticks_nxt = 16'h0000;
          if (active_kind_r != FK_READ) begin
            // write response: must echo the request
            mismatch_nxt = mismatch_r || (rx_b != sent_frame_r[rx_index_r[2:0]]);
            rx_index_nxt = rx_index_r + RXI_W'(1);
            if (rx_index_r >= RXI_W'(FRAME_LEN - 1)) begin
              res_b.res[0] = status_beat(mismatch_nxt ? ST_FAIL : ST_OK);
              res_b.cnt    = BCNT_W'(1);
              busy_nxt     = 1'b0;
            end
          end else if (rx_index_r < data_end) begin
            // read response body, covered by the CRC
            run_crc_nxt  = crc_byte(run_crc_r, rx_b);
            rx_index_nxt = rx_index_r + RXI_W'(1);
            if (rx_index_r >= RXI_W'(3)) begin
              if (rx_index_r[0]) begin
                high_hold_nxt = rx_b;
              end else begin
                rs_we   = 1'b1;
                rs_addr = idx_m4[REGI_W:1];
                rs_data = {high_hold_r, rx_b};
              end
            end
          end else if (rx_index_r == data_end) begin
            crc_low_nxt  = rx_b;
            rx_index_nxt = rx_index_r + RXI_W'(1);
          end else begin
            // CRC high byte closes the read
            busy_nxt = 1'b0;
            if (run_crc_r != {rx_b, crc_low_r}) begin
              res_b.res[0] = status_beat(ST_FAIL);
              res_b.cnt    = BCNT_W'(1);
            end else begin
              for (int i = 0; i < MAX_REGS; i++) begin
                if (i < int'(exp_regs_r)) begin
                  res_b.res[i] = out_item_t'{out_kind: KIND_WORD, out_data: reg_store_r[i],
                                             status: ST_OK, last: 1'b0};
                end
              end
              for (int i = 0; i < BUNDLE_DEPTH; i++) begin
                if (i == int'(exp_regs_r)) begin
                  res_b.res[i] = status_beat(ST_OK);
                end
              end
              res_b.cnt = BCNT_W'(exp_regs_r) + BCNT_W'(1);
            end
          end
        end
      end

      MODE_TICK: begin
        if (busy_r) begin
          if (idle_ticks_r >= timeout_limit_r) begin
            res_b.res[0] = status_beat(ST_TIMEOUT);
            res_b.cnt    = BCNT_W'(1);
            busy_nxt     = 1'b0;
          end else begin
            idle_ticks_nxt = idle_ticks_r + 16'd1;
          end
        end
      end

      default: begin
      end
    endcase
  end

  // Events without results never wait for the output side
  always_comb begin
    fire         = item_v && ((res_b.cnt == '0) || slot_ready);
    take         = fire;
    bundle       = res_b;
    bundle.valid = fire && (res_b.cnt != '0);
  end

  // Configuration and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_id_r                <= SLAVE_ID_RESET;
      timeout_limit_r           <= TIMEOUT_RESET;
      crc_pre_r[FK_READ]        <= crc_prefix(SLAVE_ID_RESET, FC_READ_HOLDING);
      crc_pre_r[FK_WRITE_COIL]  <= crc_prefix(SLAVE_ID_RESET, FC_WRITE_COIL);
      crc_pre_r[FK_WRITE_REG]   <= crc_prefix(SLAVE_ID_RESET, FC_WRITE_REG);
      busy_r                    <= 1'b0;
      active_kind_r             <= FK_READ;
      rx_index_r                <= '0;
      run_crc_r                 <= CRC_INIT;
      crc_low_r                 <= 8'h00;
      mismatch_r                <= 1'b0;
      idle_ticks_r              <= 16'h0000;
      exp_regs_r                <= '0;
      high_hold_r               <= 8'h00;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_SLAVE_ID: begin
            slave_id_r               <= cfg.data[7:0];
            crc_pre_r[FK_READ]       <= crc_prefix(cfg.data[7:0], FC_READ_HOLDING);
            crc_pre_r[FK_WRITE_COIL] <= crc_prefix(cfg.data[7:0], FC_WRITE_COIL);
            crc_pre_r[FK_WRITE_REG]  <= crc_prefix(cfg.data[7:0], FC_WRITE_REG);
          end
          REG_TIMEOUT: timeout_limit_r <= cfg.data;
          default: begin
          end
        endcase
      end
      if (fire) begin
        busy_r        <= busy_nxt;
        active_kind_r <= active_kind_nxt;
        rx_index_r    <= rx_index_nxt;
        run_crc_r     <= run_crc_nxt;
        crc_low_r     <= crc_low_nxt;
        mismatch_r    <= mismatch_nxt;
        idle_ticks_r  <= idle_ticks_nxt;
        exp_regs_r    <= exp_regs_nxt;
        high_hold_r   <= high_hold_nxt;
      end
    end
  end

  // Sent frame and read words
  always_ff @(posedge clk) begin
    if (fire && sf_we) begin
      for (int i = 0; i < FRAME_LEN; i++) begin
        sent_frame_r[i] <= frame[i];
      end
    end
    if (fire && rs_we) begin
      reg_store_r[rs_addr] <= rs_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/mrm_out_ser.sv
`default_nettype none

module mrm_out_ser (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mrm_pkg::bundle_t bundle,
  output logic                  slot_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output mrm_pkg::out_item_t    out_item
);
  import mrm_pkg::*;

  logic              held_v_r, held_v_nxt;
  logic [BIDX_W-1:0] idx_r,    idx_nxt;
  bundle_t           held_r;
  logic              beat;
  logic              last_beat;

  assign out_valid  = held_v_r;
  assign out_item   = held_r.res[idx_r];
  assign beat       = held_v_r && out_ready;
  assign last_beat  = (BCNT_W'(idx_r) == held_r.cnt - BCNT_W'(1));
  assign slot_ready = !held_v_r || (beat && last_beat);

  // step through the held results, reload when a new set arrives
  always_comb begin
    held_v_nxt = held_v_r;
    idx_nxt    = idx_r;
    if (beat) begin
      if (last_beat) begin
        held_v_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + BIDX_W'(1);
      end
    end
    if (bundle.valid) begin
      held_v_nxt = 1'b1;
      idx_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_v_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      held_v_r <= held_v_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (bundle.valid) begin
      held_r <= bundle;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/modbus_rtu_master_transaction.sv
// Modbus RTU master transaction engine.
// Input channel (in_valid/in_ready/in_item): one event per beat: a start
// request, a received serial byte or a millisecond tick. Result channel
// (out_valid/out_ready/out_item): transmit bytes, read register words and one
// closing status per transaction; last marks the final result of an event.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
// index 0 is the slave address, index 1 the idle-tick timeout limit. Write
// only while no transaction results are pending.
// An event is decoded straight out of the input register in the cycle after
// its beat; its first result is offered in the cycle after the engine takes it.
// Throughput: one event per cycle. An event with k results (an accepted start
// request gives 8, a read response up to MAX_REGS+1) holds the output register
// for k beats; events without results keep flowing behind it, others wait.
// The request CRC is a three-byte step on top of a prefix that is refreshed
// when the slave address is written.
// Reset (rst_n low, synchronous): idle, no results, slave address 16,
// timeout 100. When the receiver stalls, out_item holds and in_ready drops
// as soon as an event with results finds the output register full.
`default_nettype none

module modbus_rtu_master_transaction (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire mrm_pkg::in_item_t                 in_item,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output mrm_pkg::out_item_t                     out_item,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [mrm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [15:0]                       cfg_data
);
  import mrm_pkg::*;

  logic     item_v;
  in_item_t item;
  logic     take;
  logic     slot_ready;
  bundle_t  bundle;
  cfg_wr_t  cfg;

  assign cfg_ready = 1'b1;
  assign cfg       = '{valid: cfg_valid, index: cfg_index, data: cfg_data};

  mrm_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .item_v   (item_v),
    .item     (item),
    .take     (take)
  );

  mrm_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_v     (item_v),
    .item       (item),
    .slot_ready (slot_ready),
    .take       (take),
    .bundle     (bundle)
  );

  mrm_out_ser u_out_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .bundle     (bundle),
    .slot_ready (slot_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire

FILE: rtl/core/mrm_checker.sv
`default_nettype none

module mrm_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire mrm_pkg::out_item_t            out_item
);
  import mrm_pkg::*;

  // nothing comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // a status always closes the results of its event
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.out_kind == KIND_STATUS) |-> out_item.last)
    else $error("status beat without last");

  // a read word is always followed by more results and carries status ok
  a_word_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.out_kind == KIND_WORD) |-> !out_item.last && out_item.status == ST_OK)
    else $error("word beat marked last or with status");

  // transmit bytes carry an 8-bit value and no status
  a_tx_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.out_kind == KIND_TX) |->
      (out_item.out_data[15:8] == 8'h00) && (out_item.status == ST_OK))
    else $error("malformed transmit beat");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

endmodule

bind modbus_rtu_master_transaction mrm_checker u_mrm_checker (.*);

`default_nettype wire

FILE: dv/tb_modbus_rtu_master_transaction.sv
`default_nettype none

module tb_modbus_rtu_master_transaction;
  timeunit 1ns;
  timeprecision 1ps;

  import mrm_pkg::*;

  localparam int WATCHDOG_NS = 2_000_000;
  localparam logic [1:0] MODE_NONE    = 2'd3;
  localparam logic [1:0] FK_UNDEFINED = 2'd3;

  typedef logic [7:0][7:0] frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  modbus_rtu_master_transaction u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register copies, shared by the stimulus builder and the engine model
  logic [7:0]  slave_cfg = SLAVE_ID_RESET;
  logic [15:0] limit_cfg = TIMEOUT_RESET;

  // Engine model state
  logic        m_busy = 1'b0;
  logic [1:0]  m_kind = FK_READ;
  frame_t      m_frame = '0;
  logic [3:0]  m_rx_idx = '0;
  logic [15:0] m_crc = CRC_INIT;
  logic [7:0]  m_crc_lo = '0;
  logic        m_mismatch = 1'b0;
  logic [15:0] m_idle = '0;
  logic [2:0]  m_nregs = '0;
  logic [7:0]  m_hi = '0;
  logic [15:0] m_words [MAX_REGS];

  in_item_t    event_q[$];
  out_item_t   engine_beats[$];
  logic [7:0]  reply_bytes[$];

  int  live_events = 0;
  int  events_taken = 0;
  int  beats_checked = 0;
  int  error_count = 0;
  int  status_seen [4] = '{0, 0, 0, 0};
  int  in_hold = 0;
  int  out_hold = 0;
  bit  bursts_on = 1'b1;

  function automatic logic [15:0] crc16_modbus(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  // Request frame: slave, code, addr hi/lo, value or count hi/lo, CRC lo/hi
  function automatic frame_t request_frame(input logic [7:0] slave, input logic [1:0] fk,
                                           input logic [7:0] addr, input logic [15:0] val,
                                           input logic [6:0] cnt);
    frame_t f;
    logic [15:0] c;
    f[0] = slave;
    case (fk)
      FK_READ:       f[1] = FC_READ_HOLDING;
      FK_WRITE_COIL: f[1] = FC_WRITE_COIL;
      default:       f[1] = FC_WRITE_REG;
    endcase
    f[2] = 8'h00;
    f[3] = addr;
    f[4] = (fk == FK_READ) ? 8'h00 : val[15:8];
    f[5] = (fk == FK_READ) ? {1'b0, cnt} : val[7:0];
    c = CRC_INIT;
    for (int i = 0; i < 6; i++) c = crc16_modbus(c, f[i]);
    f[6] = c[7:0];
    f[7] = c[15:8];
    return f;
  endfunction

  task automatic push_result(input logic [1:0] kind, input logic [15:0] data,
                             input logic [1:0] st, input logic fin);
    engine_beats.push_back('{out_kind: kind, out_data: data, status: st, last: fin});
  endtask

  task automatic close_transaction(input logic [1:0] st);
    push_result(KIND_STATUS, 16'h0000, st, 1'b1);
    m_busy = 1'b0;
  endtask

  // Engine model: one accepted event in, its result beats queued
  task automatic modbus_engine_step(input in_item_t ev);
    logic [3:0] idx;
    logic [4:0] data_end;
    idx = m_rx_idx;
    data_end = 5'(2 * m_nregs + 3);
    case (ev.mode)
      MODE_START: begin
        if (m_busy || ev.func_kind == FK_UNDEFINED ||
            (ev.func_kind == FK_READ && (ev.reg_count == 0 || ev.reg_count > MAX_REGS))) begin
          push_result(KIND_STATUS, 16'h0000, ST_BAD, 1'b1);
        end else begin
          m_frame = request_frame(slave_cfg, ev.func_kind, ev.reg_address, ev.write_value,
                                  ev.reg_count);
          m_busy = 1'b1;
          m_kind = ev.func_kind;
          m_rx_idx = '0;
          m_crc = CRC_INIT;
          m_crc_lo = '0;
          m_mismatch = 1'b0;
          m_idle = '0;
          m_nregs = (ev.func_kind == FK_READ) ? ev.reg_count[2:0] : 3'd0;
          m_hi = '0;
          for (int i = 0; i < 8; i++) push_result(KIND_TX, {8'h00, m_frame[i]}, ST_OK, i == 7);
        end
      end
      MODE_RX: begin
        if (m_busy) begin
          m_idle = '0;
          if (m_kind != FK_READ) begin
            // write: echo compare against the sent frame
            if (ev.rx_byte != m_frame[idx[2:0]]) m_mismatch = 1'b1;
            m_rx_idx = idx + 4'd1;
            if (idx >= 4'd7) close_transaction(m_mismatch ? ST_FAIL : ST_OK);
          end else if (idx < data_end) begin
            m_crc = crc16_modbus(m_crc, ev.rx_byte);
            if (idx >= 4'd3) begin
              if (idx[0]) m_hi = ev.rx_byte;
              else m_words[2'((idx - 4'd4) >> 1)] = {m_hi, ev.rx_byte};
            end
            m_rx_idx = idx + 4'd1;
          end else if (idx == data_end) begin
            m_crc_lo = ev.rx_byte;
            m_rx_idx = idx + 4'd1;
          end else if (m_crc != {ev.rx_byte, m_crc_lo}) begin
            close_transaction(ST_FAIL);
          end else begin
            for (int i = 0; i < m_nregs; i++) push_result(KIND_WORD, m_words[i], ST_OK, 1'b0);
            close_transaction(ST_OK);
          end
        end
      end
      MODE_TICK: begin
        if (m_busy) begin
          if (m_idle >= limit_cfg) close_transaction(ST_TIMEOUT);
          else m_idle = m_idle + 16'd1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_beat(input out_item_t got);
    out_item_t want;
    if (engine_beats.size() == 0) begin
      $error("result beat with nothing outstanding: kind %0d data %h status %0d",
             got.out_kind, got.out_data, got.status);
      error_count++;
    end else begin
      want = engine_beats.pop_front();
      beats_checked++;
      if (got.out_kind !== want.out_kind) begin
        $error("out_kind: expected %0d, actual %0d", want.out_kind, got.out_kind);
        error_count++;
      end
      if (got.out_data !== want.out_data) begin
        $error("out_data: expected %h, actual %h", want.out_data, got.out_data);
        error_count++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        error_count++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        error_count++;
      end
      if (want.out_kind == KIND_STATUS) status_seen[want.status]++;
    end
  endtask

  // Input driver: presents queued events, with random gaps between beats
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_hold <= 0;
    end else begin
      if (in_valid && in_ready) begin
        modbus_engine_step(in_item);
        events_taken++;
      end
      if (!in_valid || in_ready) begin
        if (in_hold != 0) begin
          in_hold <= in_hold - 1;
          in_valid <= 1'b0;
        end else if (event_q.size() != 0) begin
          in_item <= event_q.pop_front();
          in_valid <= 1'b1;
          if (bursts_on && $urandom_range(0, 7) == 0) in_hold <= $urandom_range(1, 4);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each beat and stalls at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_hold <= 0;
    end else begin
      if (out_valid && out_ready) check_beat(out_item);
      if (out_hold != 0) begin
        out_hold <= out_hold - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (bursts_on && $urandom_range(0, 7) == 0) out_hold <= $urandom_range(1, 4);
      end
    end
  end

  // Random filler for every field, then the event kind on top
  function automatic in_item_t rand_event(input logic [1:0] mode);
    logic [63:0] bits;
    in_item_t e;
    bits = {$urandom, $urandom};
    e = bits[$bits(in_item_t)-1:0];
    e.mode = mode;
    return e;
  endfunction

  task automatic queue_event(input in_item_t e);
    event_q.push_back(e);
    live_events++;
  endtask

  task automatic queue_start(input logic [1:0] fk, input logic [7:0] addr,
                             input logic [15:0] val, input logic [6:0] cnt);
    in_item_t e;
    e = rand_event(MODE_START);
    e.func_kind = fk;
    e.reg_address = addr;
    e.write_value = val;
    e.reg_count = cnt;
    queue_event(e);
  endtask

  task automatic queue_rx(input logic [7:0] b);
    in_item_t e;
    e = rand_event(MODE_RX);
    e.rx_byte = b;
    queue_event(e);
  endtask

  task automatic queue_ticks(input int n);
    repeat (n) queue_event(rand_event(MODE_TICK));
  endtask

  // Read response: header, n big-endian words, CRC low then high
  task automatic build_read_reply(input logic [2:0] n);
    logic [15:0] w;
    logic [15:0] c;
    reply_bytes.delete();
    if ($urandom_range(0, 3) == 0) begin
      repeat (3) reply_bytes.push_back(8'($urandom));
    end else begin
      reply_bytes.push_back(slave_cfg);
      reply_bytes.push_back(FC_READ_HOLDING);
      reply_bytes.push_back({4'd0, n, 1'b0});
    end
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: w = 16'h0000;
        1: w = 16'hFFFF;
        default: w = 16'($urandom);
      endcase
      reply_bytes.push_back(w[15:8]);
      reply_bytes.push_back(w[7:0]);
    end
    c = CRC_INIT;
    foreach (reply_bytes[i]) c = crc16_modbus(c, reply_bytes[i]);
    reply_bytes.push_back(c[7:0]);
    reply_bytes.push_back(c[15:8]);
  endtask

  // Sends reply_bytes: mostly clean, sometimes one byte corrupted, sometimes
  // cut short and left to time out (only while the limit is small)
  task automatic queue_reply();
    int bad_at;
    int stop_at;
    int tick_max;
    bad_at = -1;
    stop_at = reply_bytes.size();
    tick_max = (limit_cfg < 3) ? int'(limit_cfg) : 3;
    case ($urandom_range(0, 9))
      0, 1: bad_at = $urandom_range(0, reply_bytes.size() - 1);
      2: if (limit_cfg <= 8) stop_at = $urandom_range(0, reply_bytes.size() - 1);
      default: ;
    endcase
    for (int i = 0; i < stop_at; i++) begin
      // idle ticks up to the limit itself never expire the transaction
      if ($urandom_range(0, 4) == 0) queue_ticks($urandom_range(1, tick_max));
      if (i == bad_at) queue_rx(reply_bytes[i] ^ 8'($urandom_range(1, 255)));
      else queue_rx(reply_bytes[i]);
    end
    if (stop_at < reply_bytes.size()) queue_ticks(int'(limit_cfg) + 1);
    reply_bytes.delete();
  endtask

  task automatic maybe_busy_start();
    if ($urandom_range(0, 9) == 0) queue_event(rand_event(MODE_START));
  endtask

  task automatic queue_write_txn();
    frame_t f;
    logic [1:0] fk;
    logic [7:0] addr;
    logic [15:0] val;
    fk = ($urandom_range(0, 1) != 0) ? FK_WRITE_REG : FK_WRITE_COIL;
    addr = 8'($urandom);
    val = 16'($urandom);
    f = request_frame(slave_cfg, fk, addr, val, 7'd0);
    queue_start(fk, addr, val, 7'($urandom));
    maybe_busy_start();
    for (int i = 0; i < 8; i++) reply_bytes.push_back(f[i]);
    queue_reply();
  endtask

  task automatic queue_read_txn();
    logic [2:0] n;
    n = 3'($urandom_range(1, MAX_REGS));
    queue_start(FK_READ, 8'($urandom), 16'($urandom), {4'd0, n});
    maybe_busy_start();
    build_read_reply(n);
    queue_reply();
  endtask

  task automatic queue_random_sequence();
    in_item_t e;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // stray events while idle: dropped by the engine
      case ($urandom_range(0, 2))
        0: e = rand_event(MODE_NONE);
        1: e = rand_event(MODE_RX);
        default: e = rand_event(MODE_TICK);
      endcase
      event_q.push_back(e);
    end else if (pick < 18) begin
      e = rand_event(MODE_START);
      case ($urandom_range(0, 2))
        0: e.func_kind = FK_UNDEFINED;
        1: begin
          e.func_kind = FK_READ;
          e.reg_count = '0;
        end
        default: begin
          e.func_kind = FK_READ;
          e.reg_count = 7'($urandom_range(MAX_REGS + 1, 127));
        end
      endcase
      queue_event(e);
    end else if (pick < 55) begin
      queue_write_txn();
    end else begin
      queue_read_txn();
    end
  endtask

  task automatic queue_phase(input int n_events);
    int first;
    first = live_events;
    while (live_events - first < n_events) queue_random_sequence();
  endtask

  // Waits until every event is taken and every result has come back
  task automatic drain();
    do @(negedge clk); while (event_q.size() != 0 || in_valid || engine_beats.size() != 0);
    repeat (6) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_SLAVE_ID) slave_cfg = data[7:0];
    else if (idx == REG_TIMEOUT) limit_cfg = data;
  endtask

  // Stimulus
  initial begin
    frame_t f;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: stray events, rejected requests, one write and one read
    event_q.push_back(rand_event(MODE_RX));
    event_q.push_back(rand_event(MODE_TICK));
    event_q.push_back(rand_event(MODE_NONE));
    queue_start(FK_UNDEFINED, 8'h00, 16'h0000, 7'd1);
    queue_start(FK_READ, 8'h12, 16'h0000, 7'd0);
    queue_start(FK_READ, 8'h12, 16'h0000, 7'(MAX_REGS + 1));
    queue_start(FK_READ, 8'h12, 16'hFFFF, 7'd127);
    f = request_frame(slave_cfg, FK_WRITE_COIL, 8'h00, 16'hFFFF, 7'd0);
    queue_start(FK_WRITE_COIL, 8'h00, 16'hFFFF, 7'd0);
    queue_start(FK_WRITE_REG, 8'hFF, 16'h0000, 7'd3);
    for (int i = 0; i < 8; i++) queue_rx(f[i]);
    queue_start(FK_READ, 8'hFF, 16'h0000, 7'd1);
    build_read_reply(3'd1);
    foreach (reply_bytes[i]) queue_rx(reply_bytes[i]);
    reply_bytes.delete();
    drain();

    // timeout limit of 1, highest slave address
    cfg_write(REG_SLAVE_ID, 16'h00FF);
    cfg_write(REG_TIMEOUT, 16'd1);
    queue_phase(45);
    drain();

    // longest timeout, slave address zero
    cfg_write(REG_SLAVE_ID, 16'h0000);
    cfg_write(REG_TIMEOUT, 16'hFFFF);
    queue_phase(35);
    drain();

    // closing stretch at full rate on both sides
    cfg_write(REG_SLAVE_ID, {8'h00, 8'($urandom)});
    cfg_write(REG_TIMEOUT, 16'd3);
    bursts_on = 1'b0;
    queue_phase(45);
    drain();
    repeat (10) @(negedge clk);

    $display("covered %0d events and %0d result beats over four slave/timeout settings",
             events_taken, beats_checked);
    $display("closing statuses: ok %0d, check failed %0d, timeout %0d, bad request %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #WATCHDOG_NS;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
